// ===== src/mse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg
// shared types, opcodes and constants of the subset execute unit
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int unsigned XLEN      = 32;
	localparam int unsigned REG_COUNT = 32;
	localparam int unsigned REG_AW    = $clog2(REG_COUNT);

	localparam logic [XLEN-1:0] BOOT_RESET       = 32'hBFC0_0000;
	localparam logic [XLEN-1:0] JUMP_REGION_MASK = 32'hF000_0000;
	localparam logic [XLEN-1:0] PC_STEP          = 32'd4;
	localparam int unsigned     IMM_W            = 16;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'b000000;
	localparam logic [5:0] OP_J       = 6'b000010;
	localparam logic [5:0] OP_ADDIU   = 6'b001001;
	localparam logic [5:0] OP_ORI     = 6'b001101;
	localparam logic [5:0] OP_LUI     = 6'b001111;
	localparam logic [5:0] OP_SW      = 6'b101011;

	// function codes under OP_SPECIAL
	localparam logic [5:0] FN_SLL = 6'b000000;
	localparam logic [5:0] FN_OR  = 6'b100101;

	// register write-back request
	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [XLEN-1:0]   data;
	} wb_t;

	// one result request
	typedef struct packed {
		logic            fault;
		logic [XLEN-1:0] store_data;
		logic [XLEN-1:0] store_address;
		logic            store_valid;
		logic [XLEN-1:0] fetch_address;
	} result_t;

endpackage
`default_nettype wire

// ===== src/mse_regfile.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_regfile
// general registers: one write port, two registered read ports, valid bits
// for the all-zero reset and bypass of a write landing on the read edge
// ----------------------------------------------------------------------------
module mse_regfile (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rd_en,
	input  wire logic [mse_pkg::REG_AW-1:0] rs_addr,
	input  wire logic [mse_pkg::REG_AW-1:0] rt_addr,
	output logic      [mse_pkg::XLEN-1:0]   rs_data,
	output logic      [mse_pkg::XLEN-1:0]   rt_data,
	input  wire mse_pkg::wb_t              wb
);

	logic [mse_pkg::XLEN-1:0]      mem [mse_pkg::REG_COUNT];
	logic [mse_pkg::REG_COUNT-1:0] vld_q;

	logic [mse_pkg::XLEN-1:0] rs_mem_s1, rt_mem_s1, byp_data_s1;
	logic                     rs_vld_s1, rt_vld_s1, rs_byp_s1, rt_byp_s1;

	always_ff @(posedge clk) begin
		if (wb.en) begin
			mem[wb.addr] <= wb.data;
		end
		if (rd_en) begin
			rs_mem_s1   <= mem[rs_addr];
			rt_mem_s1   <= mem[rt_addr];
			byp_data_s1 <= wb.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rs_vld_s1 <= 1'b0;
			rt_vld_s1 <= 1'b0;
			rs_byp_s1 <= 1'b0;
			rt_byp_s1 <= 1'b0;
		end else begin
			if (wb.en) begin
				vld_q[wb.addr] <= 1'b1;
			end
			if (rd_en) begin
				rs_vld_s1 <= vld_q[rs_addr];
				rt_vld_s1 <= vld_q[rt_addr];
				rs_byp_s1 <= wb.en && (wb.addr == rs_addr);
				rt_byp_s1 <= wb.en && (wb.addr == rt_addr);
			end
		end
	end

	always_comb begin
		rs_data = rs_byp_s1 ? byp_data_s1 : (rs_vld_s1 ? rs_mem_s1 : '0);
		rt_data = rt_byp_s1 ? byp_data_s1 : (rt_vld_s1 ? rt_mem_s1 : '0);
	end

	// register zero must never be written
	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		wb.en |-> (wb.addr != '0))
		else $error("write to register zero");

	// a write to the rs address on a read edge is always bypassed on the rs port
	a_byp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wb.en && (wb.addr == rs_addr)) |=> rs_byp_s1)
		else $error("rs bypass lost");

	// a written entry is marked valid and stays valid
	a_vld_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wb.en |=> vld_q[$past(wb.addr)])
		else $error("valid bit not set after write");

endmodule
`default_nettype wire

// ===== src/mse_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_exec
// decode and execute of the pending instruction, next program counter
// ----------------------------------------------------------------------------
module mse_exec (
	input  wire logic [mse_pkg::XLEN-1:0] ins,
	input  wire logic [mse_pkg::XLEN-1:0] pc,
	input  wire logic [mse_pkg::XLEN-1:0] rs_val,
	input  wire logic [mse_pkg::XLEN-1:0] rt_val,
	output mse_pkg::result_t              res,
	output mse_pkg::wb_t                  wb
);

	logic [5:0]                 op, fn;
	logic [mse_pkg::REG_AW-1:0] rt, rd;
	logic [4:0]                 sh;
	logic [mse_pkg::XLEN-1:0]   imm_ze, imm_se, pc_inc, jump_pc;

	always_comb begin
		op      = ins[31:26];
		rt      = ins[20:16];
		rd      = ins[15:11];
		sh      = ins[10:6];
		fn      = ins[5:0];
		imm_ze  = {{(mse_pkg::XLEN-mse_pkg::IMM_W){1'b0}}, ins[15:0]};
		imm_se  = {{(mse_pkg::XLEN-mse_pkg::IMM_W){ins[15]}}, ins[15:0]};
		pc_inc  = pc + mse_pkg::PC_STEP;
		jump_pc = (pc & mse_pkg::JUMP_REGION_MASK) | {4'b0000, ins[25:0], 2'b00};

		res               = '0;
		res.fetch_address = pc_inc;
		wb                = '0;
		wb.addr           = rt;

		unique case (op)
			mse_pkg::OP_LUI: begin
				wb.en   = 1'b1;
				wb.data = {ins[15:0], {mse_pkg::IMM_W{1'b0}}};
			end
			mse_pkg::OP_ORI: begin
				wb.en   = 1'b1;
				wb.data = rs_val | imm_ze;
			end
			mse_pkg::OP_ADDIU: begin
				wb.en   = 1'b1;
				wb.data = rs_val + imm_se;
			end
			mse_pkg::OP_SW: begin
				res.store_valid   = 1'b1;
				res.store_address = rs_val + imm_se;
				res.store_data    = rt_val;
			end
			mse_pkg::OP_J: begin
				res.fetch_address = jump_pc;
			end
			mse_pkg::OP_SPECIAL: begin
				wb.addr = rd;
				unique case (fn)
					mse_pkg::FN_SLL: begin
						wb.en   = 1'b1;
						wb.data = rt_val << sh;
					end
					mse_pkg::FN_OR: begin
						wb.en   = 1'b1;
						wb.data = rs_val | rt_val;
					end
					default: res.fault = 1'b1;
				endcase
			end
			default: res.fault = 1'b1;
		endcase

		// writes to register zero are dropped
		if (wb.addr == '0) begin
			wb.en = 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== src/mse_result_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_result_fifo
// two-entry result buffer between the execute step and the output stream
// ----------------------------------------------------------------------------
module mse_result_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mse_pkg::result_t push_data,
	output logic                  full,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mse_pkg::result_t      out_data
);

	mse_pkg::result_t entry_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	always_comb begin
		full      = (count_q == 2'd2);
		out_valid = (count_q != 2'd0);
		out_data  = entry_q[rd_ptr_q];
		pop       = out_valid && out_ready;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ===== src/mips_subset_execute_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// subset integer core: executes the pending word, one delay slot, reports
// the next fetch address and any store request
// ----------------------------------------------------------------------------
//
// channel   dir  signals                      content
// -------   ---  ---------------------------  ------------------------------
// s_*       in   s_tvalid s_tready s_tdata    instruction_word [31:0]
// m_*       out  m_tvalid m_tready m_tdata    fetch_address [31:0],
//                m_tuser                      store_address [63:32],
//                                             store_data [95:64];
//                                             tuser: store_valid [0], fault [1]
// cfg_*     in   cfg_wr_en cfg_wr_data        boot_address, loads the counter
//
// one instruction per clock while the output buffer has room: an accepted request
// executes the pending word and that result is written into a two-entry output buffer
// the operand reads of a word are issued the cycle it is accepted, so the
// register file read latency is hidden behind the delay-slot pending word;
// a write on that same edge is bypassed
// s_tready drops only while both output buffer entries are occupied
// reset loads the counter with 0xBFC00000, clears the pending word to a nop
// and clears the register valid bits, so all registers read zero at once
//
module mips_subset_execute_unit (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [31:0]              s_tdata,     // instruction_word
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic      [95:0]              m_tdata,     // fetch_address, store_address, store_data
	output logic      [1:0]               m_tuser,     // store_valid, fault
	input  wire logic                     cfg_wr_en,
	input  wire logic [mse_pkg::XLEN-1:0] cfg_wr_data  // boot_address
);

	// architectural state outside the register file
	logic [mse_pkg::XLEN-1:0] pc_q;
	logic [mse_pkg::XLEN-1:0] pending_q;

	logic                     in_acc;
	logic                     buf_full;
	logic [mse_pkg::XLEN-1:0] rs_val, rt_val;
	mse_pkg::result_t         res, out_res;
	mse_pkg::wb_t             wb_req, wb;

	assign s_tready = !buf_full;
	assign in_acc   = s_tvalid && s_tready;

	// write-back only happens when the request is taken
	always_comb begin
		wb    = wb_req;
		wb.en = wb_req.en && in_acc;
	end

	// operands of the arriving word are fetched while it becomes pending
	mse_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rs_addr (s_tdata[25:21]),
		.rt_addr (s_tdata[20:16]),
		.rs_data (rs_val),
		.rt_data (rt_val),
		.wb      (wb)
	);

	mse_exec u_exec (
		.ins    (pending_q),
		.pc     (pc_q),
		.rs_val (rs_val),
		.rt_val (rt_val),
		.res    (res),
		.wb     (wb_req)
	);

	mse_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_data (res),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// counter and pending word advance per accepted request; a config write loads the counter instead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= mse_pkg::BOOT_RESET;
			pending_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				pc_q <= cfg_wr_data;
			end else if (in_acc) begin
				pc_q <= res.fetch_address;
			end
			if (in_acc) begin
				pending_q <= s_tdata;
			end
		end
	end

	assign m_tdata = {out_res.store_data, out_res.store_address, out_res.fetch_address};
	assign m_tuser = {out_res.fault, out_res.store_valid};

	// every accepted request leaves a result behind
	a_acc_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> m_tvalid)
		else $error("accepted request produced no result");

	// input stalls only with a full buffer, which shows a result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// a faulting instruction never issues a store or a register write
	a_fault_nostore: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && res.fault) |-> (!res.store_valid && !wb.en))
		else $error("faulting instruction had an effect");

	// counter follows the reported fetch address
	a_pc_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !cfg_wr_en) |=> (pc_q == $past(res.fetch_address)))
		else $error("counter diverged from fetch address");

endmodule
`default_nettype wire
